[rtl/isbe_pkg.sv]
// shared types and constants for the i2c slave bus engine
package isbe_pkg;

	localparam int STUCK_TICKS_DEF = 1000;
	localparam int BITS_PER_BYTE   = 8;
	localparam int ADDR_W          = 7;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OWN_ADDRESS   = 2'd0,
		CFG_TRANSFER_SIZE = 2'd1,
		CFG_START_TIMEOUT = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		EV_NONE     = 4'd0,
		EV_START    = 4'd1,
		EV_ADDR_WR  = 4'd2,
		EV_ADDR_RD  = 4'd3,
		EV_BYTE_RX  = 4'd4,
		EV_BYTE_TX  = 4'd5,
		EV_STOP     = 4'd6,
		EV_RESTART  = 4'd7,
		EV_MISMATCH = 4'd8,
		EV_SCL_STUCK = 4'd9,
		EV_MASTER_NAK = 4'd10,
		EV_TIMEOUT  = 4'd11,
		EV_BUSY     = 4'd12
	} event_t;

	typedef enum logic [9:0] {
		PH_IDLE     = 10'b00_0000_0001,
		PH_BUSY     = 10'b00_0000_0010,
		PH_ADDR     = 10'b00_0000_0100,
		PH_ADDR_ACK = 10'b00_0000_1000,
		PH_RX       = 10'b00_0001_0000,
		PH_RX_ACK   = 10'b00_0010_0000,
		PH_TX       = 10'b00_0100_0000,
		PH_TX_ACK   = 10'b00_1000_0000,
		PH_WAIT_END = 10'b01_0000_0000,
		PH_RX_NAK   = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic       scl_in;
		logic       sda_in;
		logic [7:0] tx_byte;
	} in_item_t;

	typedef struct packed {
		logic       sda_release;
		logic [3:0] event_res;
		logic [7:0] rx_byte;
		logic [7:0] byte_count;
		logic       tx_taken;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] own_address;
		logic [7:0]        transfer_size;
		logic [15:0]       start_timeout;
	} cfg_t;

endpackage

[rtl/isbe_engine.sv]
// bus state machine: line sampling, shifter, counters and per-item result
module isbe_engine import isbe_pkg::*; #(
	parameter int STUCK_TICKS = STUCK_TICKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  sample,
	input  cfg_t      cfg,
	output out_item_t result
);

	localparam logic [15:0] STUCK_LIM = 16'(STUCK_TICKS);
	localparam logic [3:0]  BYTE_BITS = 4'(BITS_PER_BYTE);

	phase_t      phase_q, phase_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  count_q, count_d;
	logic        prev_scl_q, prev_sda_q;
	logic        tx_q, tx_d;
	logic [15:0] tick_q, tick_d;

	event_t      ev;
	logic [7:0]  rxb;
	logic        taken;
	logic        rel;
	logic        scl, sda, high, start, stop, rise, fall, active;
	logic [15:0] tick_inc, tick_a;
	logic [3:0]  bit_inc;

	always_comb begin
		scl      = sample.scl_in;
		sda      = sample.sda_in;
		high     = prev_scl_q & scl;
		start    = high & prev_sda_q & ~sda;
		stop     = high & ~prev_sda_q & sda;
		rise     = ~prev_scl_q & scl;
		fall     = prev_scl_q & ~scl;
		tick_inc = tick_q + 16'd1;
		tick_a   = scl ? ((tick_q != 16'hFFFF) ? tick_inc : tick_q) : 16'd0;
		bit_inc  = bit_q + 4'd1;
		active   = (phase_q == PH_ADDR) || (phase_q == PH_ADDR_ACK) || (phase_q == PH_RX) ||
			(phase_q == PH_RX_ACK) || (phase_q == PH_TX) || (phase_q == PH_TX_ACK) ||
			(phase_q == PH_WAIT_END) || (phase_q == PH_RX_NAK);

		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		count_d = count_q;
		tx_d    = tx_q;
		tick_d  = tick_q;
		ev      = EV_NONE;
		rxb     = 8'd0;
		taken   = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (start) begin
				ev = EV_START; phase_d = PH_ADDR; bit_d = 4'd0; shift_d = 8'd0;
				count_d = 8'd0; tick_d = 16'd0;
			end else if (!(scl && sda)) begin
				ev = EV_BUSY; phase_d = PH_BUSY; tick_d = 16'd0;
			end else if (tick_inc >= cfg.start_timeout) begin
				ev = EV_TIMEOUT; tick_d = 16'd0;
			end else begin
				tick_d = tick_inc;
			end
		end else if (!active) begin
			tick_d  = 16'd0;
			phase_d = stop ? PH_IDLE : PH_BUSY;
		end else begin
			tick_d = tick_a;
			if (stop) begin
				ev = EV_STOP; phase_d = PH_IDLE; tick_d = 16'd0;
			end else if (start) begin
				ev = EV_RESTART; phase_d = PH_ADDR; bit_d = 4'd0; shift_d = 8'd0;
				count_d = 8'd0;
			end else if (tick_a >= STUCK_LIM) begin
				ev = EV_SCL_STUCK; phase_d = PH_BUSY; tick_d = 16'd0;
			end else begin
				case (phase_q)
					PH_ADDR, PH_RX: begin
						if (rise && bit_q < BYTE_BITS) begin
							shift_d = {shift_q[6:0], sda};
							bit_d   = bit_inc;
						end else if (fall && bit_q >= BYTE_BITS) begin
							bit_d = 4'd0;
							rxb   = shift_q;
							if (phase_q == PH_ADDR) begin
								if (shift_q[7:1] != cfg.own_address) begin
									ev = EV_MISMATCH; phase_d = PH_BUSY; tick_d = 16'd0;
								end else begin
									tx_d    = shift_q[0];
									ev      = shift_q[0] ? EV_ADDR_RD : EV_ADDR_WR;
									phase_d = PH_ADDR_ACK;
								end
							end else if (count_q < cfg.transfer_size) begin
								count_d = count_q + 8'd1; ev = EV_BYTE_RX; phase_d = PH_RX_ACK;
							end else begin
								rxb = 8'd0; phase_d = PH_RX_NAK;
							end
						end
					end
					PH_ADDR_ACK: begin
						if (fall) begin
							if (tx_q) begin
								if (count_q < cfg.transfer_size) begin
									shift_d = sample.tx_byte; bit_d = 4'd0;
									phase_d = PH_TX; taken = 1'b1;
								end else begin
									phase_d = PH_WAIT_END;
								end
							end else begin
								phase_d = PH_RX; bit_d = 4'd0; shift_d = 8'd0;
							end
						end
					end
					PH_RX_ACK, PH_RX_NAK: begin
						if (fall) begin
							phase_d = PH_RX; bit_d = 4'd0; shift_d = 8'd0;
						end
					end
					PH_TX: begin
						if (fall) begin
							if (bit_inc >= BYTE_BITS) begin
								bit_d = 4'd0; shift_d = 8'd0; phase_d = PH_TX_ACK;
								count_d = count_q + 8'd1; ev = EV_BYTE_TX;
							end else begin
								bit_d   = bit_inc;
								shift_d = {shift_q[6:0], 1'b0};
							end
						end
					end
					PH_TX_ACK: begin
						if (rise) begin
							shift_d = {7'd0, sda};
						end else if (fall) begin
							if (shift_q[0]) begin
								ev = EV_MASTER_NAK; phase_d = PH_WAIT_END;
							end else if (count_q < cfg.transfer_size) begin
								shift_d = sample.tx_byte; bit_d = 4'd0;
								phase_d = PH_TX; taken = 1'b1;
							end else begin
								phase_d = PH_WAIT_END;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end

		case (phase_d)
			PH_ADDR_ACK, PH_RX_ACK: rel = 1'b0;
			PH_TX:                  rel = shift_d[7];
			default:                rel = 1'b1;
		endcase

		result.sda_release = rel;
		result.event_res   = ev;
		result.rx_byte     = rxb;
		result.byte_count  = count_d;
		result.tx_taken    = taken;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_q      <= 4'd0;
			shift_q    <= 8'd0;
			count_q    <= 8'd0;
			prev_scl_q <= 1'b1;
			prev_sda_q <= 1'b1;
			tx_q       <= 1'b0;
			tick_q     <= 16'd0;
		end else if (step) begin
			phase_q    <= phase_d;
			bit_q      <= bit_d;
			shift_q    <= shift_d;
			count_q    <= count_d;
			prev_scl_q <= scl;
			prev_sda_q <= sda;
			tx_q       <= tx_d;
			tick_q     <= tick_d;
		end
	end

endmodule

[rtl/i2c_slave_bus_engine_top.sv]
// top level of the i2c slave bus engine
//
// in channel: one item per bus sample (scl_in, sda_in) plus the byte to send
// next; the item is taken when in_valid and in_ready are both high.
// out channel: exactly one item per input item, in order: sda drive level,
// event code, received byte, byte count and a tx_taken flag.
// cfg channel: cfg_index selects own address (0), transfer size (1) or start
// timeout (2); cfg_ready is always high, other indexes are ignored.
// result: the result of an item is registered and is on out_data in the cycle after it is taken.
// throughput: one item per cycle while out_ready is high; the engine updates its state in the same
// cycle an item is taken and the result register holds one item.
// in_ready is high whenever the result register is empty or being emptied,
// so a stalled receiver holds off the sender after one item.
// reset: bus state returns to idle with both line history bits high, the
// registers return to address 0, size 255 and timeout 65535, and the result
// register is emptied.
module i2c_slave_bus_engine_top import isbe_pkg::*; #(
	parameter int STUCK_TICKS = STUCK_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	out_item_t out_data_q;
	out_item_t result;
	logic      out_valid_q;
	logic      step;

	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	isbe_engine #(
		.STUCK_TICKS(STUCK_TICKS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (in_data),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address   <= '0;
			cfg_q.transfer_size <= 8'd255;
			cfg_q.start_timeout <= 16'hFFFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OWN_ADDRESS:   cfg_q.own_address   <= cfg_data[ADDR_W-1:0];
				CFG_TRANSFER_SIZE: cfg_q.transfer_size <= cfg_data[7:0];
				CFG_START_TIMEOUT: cfg_q.start_timeout <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= result;
		end
	end

endmodule

[rtl/isbe_checker.sv]
// port-level checks for the i2c slave bus engine, bound to the top level
module isbe_checker import isbe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// every item taken gives a result on the next cycle
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("item taken without a result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_start_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_res == EV_START || out_data.event_res == EV_RESTART)
		|-> out_data.byte_count == 8'd0)
		else $error("start with nonzero byte count");

	a_taken_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_taken |-> out_data.event_res == EV_NONE)
		else $error("tx byte loaded alongside an event");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.event_res <= EV_BUSY)
		else $error("event code out of range");

endmodule

bind i2c_slave_bus_engine_top isbe_checker u_isbe_checker (.*);
